// ----- sv/egcd_pkg.sv -----
// Shared widths and types for the extended GCD block.
// No dependencies; every other file imports this package.
`default_nettype none
package egcd_pkg;
	localparam int OPERAND_WIDTH = 32;
	localparam int COEF_WIDTH    = OPERAND_WIDTH + 1;
	localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH);

	typedef logic [OPERAND_WIDTH-1:0]       word_t;
	typedef logic signed [COEF_WIDTH-1:0]   scoef_t;
	typedef logic [CNT_WIDTH-1:0]           cnt_t;
endpackage
`default_nettype wire

// ----- sv/egcd_ifs.sv -----
// Valid/ready channel interfaces for operands and results.
// Depends on egcd_pkg.
`default_nettype none
interface egcd_req_if;
	import egcd_pkg::*;
	logic  valid;
	logic  ready;
	word_t a_value;
	word_t b_value;
	modport source(output valid, output a_value, output b_value, input ready);
	modport sink(input valid, input a_value, input b_value, output ready);
endinterface

interface egcd_rsp_if;
	import egcd_pkg::*;
	logic   valid;
	logic   ready;
	scoef_t coef_s;
	scoef_t coef_t;
	word_t  gcd_out;
	modport source(output valid, output coef_s, output coef_t, output gcd_out, input ready);
	modport sink(input valid, input coef_s, input coef_t, input gcd_out, output ready);
endinterface
`default_nettype wire

// ----- sv/extended_gcd_bezout.sv -----
// Extended Euclidean algorithm: gcd and Bezout coefficients of two operands.
// Depends on egcd_pkg and the channel interfaces in egcd_ifs.sv.
//
// channel  role    payload
// req      sink    a_value, b_value
// rsp      source  coef_s, coef_t, gcd_out
//
// A transaction runs n division steps, at most 46 for 32-bit operands.
// Each division step runs a restoring divider one quotient bit per cycle; the
// same cycle folds the bit into the quotient-times-coefficient products.
// req is ready only while idle; a result waits in the rsp register while the
// next transaction is taken. arst_n clears control state only.
`default_nettype none
module extended_gcd_bezout (
	input  wire          clk,
	input  wire          arst_n,
	egcd_req_if.sink     req,
	egcd_rsp_if.source   rsp
);
	import egcd_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CHK  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_UPD  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0] state_q;
	word_t      r0_q, r1_q, rem_q, dvd_q;
	scoef_t     s0_q, s1_q, t0_q, t1_q, accs_q, acct_q;
	cnt_t       cnt_q;
	logic       out_vld_q;
	scoef_t     out_s_q, out_t_q;
	word_t      out_g_q;

	logic [OPERAND_WIDTH:0] shifted, diff;
	logic                   qbit;
	logic                   out_free;

	assign shifted  = {rem_q, dvd_q[OPERAND_WIDTH-1]};
	assign diff     = shifted - {1'b0, r1_q};
	assign qbit     = ~diff[OPERAND_WIDTH];
	assign out_free = ~out_vld_q | rsp.ready;

	assign req.ready   = (state_q == ST_IDLE);
	assign rsp.valid   = out_vld_q;
	assign rsp.coef_s  = out_s_q;
	assign rsp.coef_t  = out_t_q;
	assign rsp.gcd_out = out_g_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free)
				out_vld_q <= 1'b1;
			else if (rsp.ready)
				out_vld_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (req.valid)
						state_q <= ST_CHK;
				end
				ST_CHK: begin
					state_q <= (r1_q == '0) ? ST_FIN : ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0)
						state_q <= ST_UPD;
				end
				ST_UPD: begin
					state_q <= ST_CHK;
				end
				ST_FIN: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				r0_q <= req.a_value;
				r1_q <= req.b_value;
				s0_q <= scoef_t'(1);
				s1_q <= '0;
				t0_q <= '0;
				t1_q <= scoef_t'(1);
			end
			ST_CHK: begin
				rem_q  <= '0;
				dvd_q  <= r0_q;
				accs_q <= '0;
				acct_q <= '0;
				cnt_q  <= cnt_t'(OPERAND_WIDTH - 1);
			end
			ST_DIV: begin
				rem_q  <= qbit ? diff[OPERAND_WIDTH-1:0] : shifted[OPERAND_WIDTH-1:0];
				dvd_q  <= {dvd_q[OPERAND_WIDTH-2:0], 1'b0};
				accs_q <= {accs_q[COEF_WIDTH-2:0], 1'b0} + (qbit ? s1_q : scoef_t'(0));
				acct_q <= {acct_q[COEF_WIDTH-2:0], 1'b0} + (qbit ? t1_q : scoef_t'(0));
				cnt_q  <= cnt_q - cnt_t'(1);
			end
			ST_UPD: begin
				r0_q <= r1_q;
				r1_q <= rem_q;
				s0_q <= s1_q;
				s1_q <= s0_q - accs_q;
				t0_q <= t1_q;
				t1_q <= t0_q - acct_q;
			end
			ST_FIN: begin
				if (out_free) begin
					out_s_q <= s0_q;
					out_t_q <= t0_q;
					out_g_q <= r0_q;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTH
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < r1_q))
		else $error("partial remainder not below divisor");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (r1_q != '0))
		else $error("division step with zero divisor");
	a_accept_chk: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == ST_CHK))
		else $error("accepted transaction did not start");
	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_free) |=> (out_vld_q && state_q == ST_IDLE))
		else $error("finished result not posted");
`endif
endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for extended_gcd_bezout: drives operand pairs, predicts gcd and
// Bezout coefficients in place and checks every result transaction in order.
// Depends on egcd_pkg, the channel interfaces in egcd_ifs.sv and the extended_gcd_bezout RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import egcd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 3_000_000;
	localparam int unsigned MAX_REPORTS = 10;
	localparam int unsigned SETTLE_CYCLES = 64;
	localparam word_t WORD_MAX = '1;

	typedef struct {
		word_t  a;
		word_t  b;
		scoef_t s;
		scoef_t t;
		word_t  g;
	} bezout_expect_t;

	logic clk = 1'b0;
	logic arst_n;
	bit no_idle;
	int unsigned cycles = 0;
	int unsigned mismatches = 0;
	int unsigned results_seen = 0;
	int unsigned coprime_seen = 0;
	bezout_expect_t bezout_q[$];
	bezout_expect_t head_exp;

	egcd_req_if req_ch();
	egcd_rsp_if rsp_ch();

	extended_gcd_bezout DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("extended_gcd_bezout regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		rsp_ch.ready <= no_idle || ($urandom_range(99) >= 20);
	end

	function automatic bezout_expect_t predict_bezout(word_t a, word_t b);
		bezout_expect_t e;
		bit [63:0] r0, r1, s0, s1, t0, t1, q, nr, ns, nt;
		r0 = 64'(a);
		r1 = 64'(b);
		s0 = 64'd1;
		s1 = 64'd0;
		t0 = 64'd0;
		t1 = 64'd1;
		while (r1 != 64'd0) begin
			q = r0 / r1;
			nr = r0 - q * r1;
			ns = s0 - q * s1;
			nt = t0 - q * t1;
			r0 = r1;
			r1 = nr;
			s0 = s1;
			s1 = ns;
			t0 = t1;
			t1 = nt;
		end
		e.a = a;
		e.b = b;
		e.s = scoef_t'(s0[COEF_WIDTH-1:0]);
		e.t = scoef_t'(t0[COEF_WIDTH-1:0]);
		e.g = word_t'(r0[OPERAND_WIDTH-1:0]);
		return e;
	endfunction

	function automatic void note_mismatch(string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("MISMATCH cycle %0d: %s", cycles, msg);
	endfunction

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (bezout_q.size() == 0) begin
				note_mismatch($sformatf("unexpected result s=%0d t=%0d gcd=%0d",
					rsp_ch.coef_s, rsp_ch.coef_t, rsp_ch.gcd_out));
			end else begin
				head_exp = bezout_q.pop_front();
				results_seen++;
				if (head_exp.g == word_t'(1))
					coprime_seen++;
				if (rsp_ch.coef_s !== head_exp.s)
					note_mismatch($sformatf("a=%0d b=%0d coef_s expected %0d got %0d",
						head_exp.a, head_exp.b, head_exp.s, rsp_ch.coef_s));
				if (rsp_ch.coef_t !== head_exp.t)
					note_mismatch($sformatf("a=%0d b=%0d coef_t expected %0d got %0d",
						head_exp.a, head_exp.b, head_exp.t, rsp_ch.coef_t));
				if (rsp_ch.gcd_out !== head_exp.g)
					note_mismatch($sformatf("a=%0d b=%0d gcd_out expected %0d got %0d",
						head_exp.a, head_exp.b, head_exp.g, rsp_ch.gcd_out));
			end
		end
	end

	// hold valid high on return so back-to-back transactions follow without a gap
	task automatic send_operands(input word_t a, input word_t b);
		while (!no_idle && $urandom_range(99) < 20) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.a_value <= a;
		req_ch.b_value <= b;
		do @(posedge clk); while (!req_ch.ready);
		bezout_q = {bezout_q, predict_bezout(a, b)};
	endtask

	task automatic test_directed_corners();
		send_operands(32'd0, 32'd0);
		send_operands(WORD_MAX, 32'd0);
		send_operands(32'd0, WORD_MAX);
		send_operands(32'd1, 32'd1);
		send_operands(32'd6, 32'd6);
		send_operands(WORD_MAX, WORD_MAX);
		send_operands(WORD_MAX, WORD_MAX - 1);
		send_operands(WORD_MAX - 1, WORD_MAX);
		send_operands(32'd2971215073, 32'd1836311903);
		send_operands(32'd1836311903, 32'd2971215073);
		send_operands(32'd3, 32'd7);
		send_operands(32'd17, 32'd3120);
		send_operands(32'd12, 32'd18);
		send_operands(32'd240, 32'd46);
		send_operands(32'h8000_0000, 32'h4000_0000);
		send_operands(32'h8000_0000, 32'd1);
		send_operands(32'd1, 32'h8000_0000);
		send_operands(32'hAAAA_AAAA, 32'h5555_5555);
		send_operands(32'h5555_5555, 32'hAAAA_AAAA);
		send_operands(32'd65537, 32'd4294967291);
		send_operands(32'd123456789, 32'd0);
		send_operands(32'd0, 32'd987654321);
		send_operands(32'd1000000007, 32'd998244353);
	endtask

	task automatic test_random_mix(input int unsigned count);
		word_t a, b, f, tmp;
		int unsigned kind, n;
		repeat (count) begin
			kind = $urandom_range(99);
			a = $urandom();
			b = $urandom();
			if (kind < 40) begin
			end else if (kind < 55) begin
				if (a > b) begin
					tmp = a;
					a = b;
					b = tmp;
				end
			end else if (kind < 70) begin
				f = $urandom_range(65535, 2);
				a = f * word_t'($urandom_range(WORD_MAX / f, 0));
				b = f * word_t'($urandom_range(WORD_MAX / f, 0));
			end else if (kind < 78) begin
				n = $urandom_range(45, 1);
				a = 32'd1;
				b = 32'd1;
				repeat (n) begin
					tmp = a + b;
					b = a;
					a = tmp;
				end
				if ($urandom_range(1) == 1) begin
					tmp = a;
					a = b;
					b = tmp;
				end
			end else if (kind < 86) begin
				a = $urandom_range(255);
				b = $urandom_range(255);
			end else if (kind < 90) begin
				if ($urandom_range(1) == 1)
					b = '0;
				else
					a = '0;
			end else if (kind < 95) begin
				b = b >> $urandom_range(31, 4);
				a = b * word_t'($urandom_range(16, 1));
			end else begin
				a = WORD_MAX - word_t'($urandom_range(15));
				b = WORD_MAX - word_t'($urandom_range(15));
			end
			send_operands(a, b);
		end
	endtask

	task automatic test_steady_stream(input int unsigned count);
		no_idle <= 1'b1;
		test_random_mix(count);
		no_idle <= 1'b0;
	endtask

	// drop valid and let every outstanding result drain before each transaction
	task automatic test_drain_pause(input int unsigned count);
		repeat (count) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while (bezout_q.size() != 0);
			send_operands($urandom(), $urandom());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		no_idle = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.a_value = '0;
		req_ch.b_value = '0;
		rsp_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_corners();
		test_random_mix(270);
		test_steady_stream(90);
		test_drain_pause(12);

		req_ch.valid <= 1'b0;
		do @(posedge clk); while (bezout_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d results: %0d coprime pairs, %0d with a shared factor or zero gcd",
			results_seen, coprime_seen, results_seen - coprime_seen);
		$display("corner, random, back-to-back and drained phases; %0d mismatches", mismatches);
		if (mismatches == 0 && bezout_q.size() == 0) begin
			$display("extended_gcd_bezout regression: pass");
		end else begin
			$display("extended_gcd_bezout regression: fail");
		end
		$finish;
	end
endmodule

// ----- filelist.f -----
sv/egcd_pkg.sv
sv/egcd_ifs.sv
sv/extended_gcd_bezout.sv
tb/sv/tb.sv
